// ===== design/mrr_pkg.sv =====
// Package for the multi-reader overwrite ring.
// Holds the entry and result types and the fixed field widths; no dependencies.
package mrr_pkg;

    localparam int SLOT_W       = 4;
    localparam int TYPE_W       = 8;
    localparam int ADDR_W       = 8;
    localparam int LEN_W        = 8;
    localparam int MASK_W       = 16;
    localparam int TIME_W       = 32;
    localparam int PAYLOAD_W    = 64;
    localparam int RESULT_LIMIT = 16;
    localparam int CNT_W        = 5;

    typedef struct packed {
        logic [MASK_W-1:0] streams;
        logic [TIME_W-1:0] stamp;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
        logic [TYPE_W-1:0] kind;
    } t_meta;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [TYPE_W-1:0]    kind;
        logic [ADDR_W-1:0]    addr;
        logic [LEN_W-1:0]     len;
        logic [MASK_W-1:0]    matched;
        logic [TIME_W-1:0]    stamp;
        logic [PAYLOAD_W-1:0] payload;
    } t_result;

endpackage

// ===== design/multi_reader_overwrite_ring.sv =====
// Multi-reader overwrite ring: sequencer, scan stage and output register.
// An add accepts the item, reads the slot, then merges and writes it back.
// A read accepts the item, then reads one slot per cycle while the output does not stall,
// through the store's single read port, oldest first, then handles the last
// match and releases it with tlast. An item with no streams is accepted and dropped.
// Reset clears control state; slots read as zero through valid bits, no sweep.
module multi_reader_overwrite_ring #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // elem_type[7:0], dest_address[15:8], payload_len[23:16],
    // stream_mask[39:24], payload[103:40], timestamp[135:104]
    input  logic [135:0] s_axis_tdata,
    // func[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // slot_index[3:0], out_type[11:4], out_address[19:12], out_length[27:20],
    // matched_streams[43:28], out_timestamp[75:44], out_payload[139:76], zero[143:140]
    output logic [143:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import mrr_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int PW  = PAYLOAD_BYTES * 8;
    localparam int IW  = $clog2(DEPTH + 1);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_ADD_RD = 2'd1;
    localparam logic [1:0] S_ADD_WR = 2'd2;
    localparam logic [1:0] S_SCAN   = 2'd3;
    localparam logic       FUNC_READ = 1'b1;

    logic [1:0]          r_state, n_state;
    logic [AW-1:0]       r_wr_slot, n_wr_slot;
    logic [AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]       r_ev_slot, n_ev_slot;
    logic [IW-1:0]       r_issued, n_issued;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_ev_v, n_ev_v;
    logic                r_held_v, n_held_v;
    logic                r_out_v, n_out_v;
    logic                r_out_last, n_out_last;
    t_result             r_held, n_held;
    t_result             r_out, n_out;
    t_meta               r_in_meta;
    logic [PW-1:0]       r_in_pay;

    logic                accept;
    logic                in_func;
    t_meta               in_meta;
    t_meta               rd_meta;
    logic [PW-1:0]       rd_pay;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    t_meta               wr_meta;
    logic [PW-1:0]       wr_pay;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [PW-1:0]       byte_mask;
    logic [MASK_W-1:0]   hit_mask;
    logic                ev_hit;
    logic                out_free;
    logic                ev_stall;
    logic                issue;
    logic                scan_done;
    logic [SLOT_W+AW-1:0] slot_ext;
    logic [PAYLOAD_W-1:0] pay_ext;
    t_result             ev_res;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_func       = s_axis_tuser[0];
    assign in_meta.kind    = s_axis_tdata[7:0];
    assign in_meta.addr    = s_axis_tdata[15:8];
    assign in_meta.len     = s_axis_tdata[23:16];
    assign in_meta.streams = s_axis_tdata[39:24];
    assign in_meta.stamp   = s_axis_tdata[135:104];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_meta <= in_meta;
            r_in_pay  <= s_axis_tdata[40 +: PW];
        end
    end

    always_comb begin
        for (int b = 0; b < PAYLOAD_BYTES; b++) begin
            byte_mask[b*8 +: 8] = {8{r_in_meta.len > LEN_W'(b)}};
        end
    end

    assign hit_mask  = rd_meta.streams & r_in_meta.streams;
    assign ev_hit    = r_ev_v && (|hit_mask) && (r_cnt < CNT_W'(RESULT_LIMIT));
    assign out_free  = !r_out_v || m_axis_tready;
    assign ev_stall  = ev_hit && r_held_v && !out_free;
    assign issue     = (r_state == S_SCAN) && (r_issued != IW'(DEPTH)) && !ev_stall;
    assign scan_done = (r_state == S_SCAN) && (r_issued == IW'(DEPTH)) && !r_ev_v;

    assign rd_en   = issue || (r_state == S_ADD_RD);
    assign rd_addr = (r_state == S_SCAN) ? r_rd_ptr : r_wr_slot;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ev_slot;
        wr_meta = rd_meta;
        wr_pay  = rd_pay;
        if (r_state == S_ADD_WR) begin
            wr_en   = 1'b1;
            wr_addr = r_wr_slot;
            wr_meta = r_in_meta;
            wr_pay  = (rd_pay & ~byte_mask) | (r_in_pay & byte_mask);
        end else if (ev_hit && !ev_stall) begin
            wr_en           = 1'b1;
            wr_meta.streams = rd_meta.streams & ~hit_mask;
        end
    end

    mrr_store #(
        .DEPTH         (DEPTH),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_meta    (wr_meta),
        .i_wr_payload (wr_pay),
        .i_rd_en      (rd_en),
        .i_rd_addr    (rd_addr),
        .o_rd_meta    (rd_meta),
        .o_rd_payload (rd_pay)
    );

    always_comb begin
        slot_ext = '0;
        slot_ext[AW-1:0] = r_ev_slot;
        pay_ext = '0;
        pay_ext[PW-1:0] = rd_pay;
        ev_res.slot    = slot_ext[SLOT_W-1:0];
        ev_res.kind    = rd_meta.kind;
        ev_res.addr    = rd_meta.addr;
        ev_res.len     = rd_meta.len;
        ev_res.matched = hit_mask;
        ev_res.stamp   = rd_meta.stamp;
        ev_res.payload = pay_ext;
    end

    always_comb begin
        n_state    = r_state;
        n_wr_slot  = r_wr_slot;
        n_rd_ptr   = r_rd_ptr;
        n_ev_slot  = r_ev_slot;
        n_issued   = r_issued;
        n_cnt      = r_cnt;
        n_ev_v     = issue ? 1'b1 : (ev_stall ? r_ev_v : 1'b0);
        n_held_v   = r_held_v;
        n_held     = r_held;
        n_out_v    = (r_out_v && m_axis_tready) ? 1'b0 : r_out_v;
        n_out      = r_out;
        n_out_last = r_out_last;

        if (issue) begin
            n_ev_slot = r_rd_ptr;
            n_issued  = r_issued + IW'(1);
            n_rd_ptr  = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end

        if (ev_hit && !ev_stall) begin
            if (r_held_v) begin
                n_out      = r_held;
                n_out_last = 1'b0;
                n_out_v    = 1'b1;
            end
            n_held   = ev_res;
            n_held_v = 1'b1;
            n_cnt    = r_cnt + CNT_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept && (|in_meta.streams)) begin
                    if (in_func == FUNC_READ) begin
                        n_state  = S_SCAN;
                        n_rd_ptr = r_wr_slot;
                        n_issued = '0;
                        n_cnt    = '0;
                    end else begin
                        n_state = S_ADD_RD;
                    end
                end
            end
            S_ADD_RD: begin
                n_state = S_ADD_WR;
            end
            S_ADD_WR: begin
                n_state   = S_IDLE;
                n_wr_slot = (r_wr_slot == AW'(DEPTH - 1)) ? '0 : r_wr_slot + AW'(1);
            end
            S_SCAN: begin
                if (scan_done) begin
                    if (!r_held_v) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        n_out      = r_held;
                        n_out_last = 1'b1;
                        n_out_v    = 1'b1;
                        n_held_v   = 1'b0;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_slot <= '0;
            r_rd_ptr  <= '0;
            r_issued  <= '0;
            r_cnt     <= '0;
            r_ev_v    <= 1'b0;
            r_held_v  <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_slot <= n_wr_slot;
            r_rd_ptr  <= n_rd_ptr;
            r_issued  <= n_issued;
            r_cnt     <= n_cnt;
            r_ev_v    <= n_ev_v;
            r_held_v  <= n_held_v;
            r_out_v   <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev_slot  <= n_ev_slot;
        r_held     <= n_held;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {4'b0000, r_out.payload, r_out.stamp, r_out.matched,
                            r_out.len, r_out.addr, r_out.kind, r_out.slot};

    a_idle_nothing_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_held_v)
        else $error("A held result remains while the ring is idle.");

    a_out_has_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (|r_out.matched))
        else $error("An output transfer carries no matched streams.");

    a_write_in_owner_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> ((r_state == S_SCAN) || (r_state == S_ADD_WR)))
        else $error("Slot write outside an add or scan.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RESULT_LIMIT))
        else $error("Result count ran past its limit.");

    a_slot_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_WR) |=> (r_wr_slot != $past(r_wr_slot)))
        else $error("Write slot did not advance after an add.");

endmodule

// ===== design/mrr_store.sv =====
// Slot store of the ring: one write port, one registered read port.
// Per-slot valid bits make unwritten slots read as zero. Uses mrr_pkg.
module mrr_store #(
    parameter int DEPTH         = 16,
    parameter int PAYLOAD_BYTES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  mrr_pkg::t_meta               i_wr_meta,
    input  logic [PAYLOAD_BYTES*8-1:0]   i_wr_payload,
    input  logic                         i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output mrr_pkg::t_meta               o_rd_meta,
    output logic [PAYLOAD_BYTES*8-1:0]   o_rd_payload
);
    import mrr_pkg::*;

    localparam int PW = PAYLOAD_BYTES * 8;

    t_meta            r_meta_mem [DEPTH];
    logic [PW-1:0]    r_pay_mem  [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic             r_rd_vld;
    t_meta            r_rd_meta;
    logic [PW-1:0]    r_rd_pay;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_meta_mem[i_wr_addr] <= i_wr_meta;
            r_pay_mem[i_wr_addr]  <= i_wr_payload;
        end
        if (i_rd_en) begin
            r_rd_meta <= r_meta_mem[i_rd_addr];
            r_rd_pay  <= r_pay_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_meta    = r_rd_vld ? r_rd_meta : '0;
    assign o_rd_payload = r_rd_vld ? r_rd_pay : '0;

endmodule
